// ----- sv/stg_pkg.sv -----
// Shared types and constants for the sine tone generator.
`default_nettype none

package stg_pkg;

    localparam int DEPTH_DEFAULT      = 1024;
    localparam int PHASE_BITS_DEFAULT = 32;

    localparam int MAG_W   = 15;
    localparam int COUNT_W = 22;

    localparam logic [15:0]        RATE_RESET    = 16'd16000;
    localparam logic [MAG_W-1:0]   AMP_RESET     = 15'd6500;
    localparam logic [15:0]        COUNT_DIVISOR = 16'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
    localparam logic [MAG_W-1:0]   MAG_MAX       = 15'd32767;

    // ceil(2^38 / 1000): floor(p / 1000) == (p * COUNT_RECIP) >> 38 for any 32-bit p
    localparam logic [28:0]        COUNT_RECIP       = 29'd274877907;
    localparam int                 COUNT_RECIP_SHIFT = 38;

    typedef enum logic [1:0] {
        REG_SAMPLE_RATE = 2'd0,
        REG_AMPLITUDE   = 2'd1
    } stg_reg_t;

    typedef struct packed {
        logic        mode;
        logic [15:0] tone_frequency;
        logic [15:0] duration_ms;
    } stg_in_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
        logic               active;
    } stg_out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_INDEX,
        OP_MUL,
        OP_EMIT_TONE,
        OP_EMIT_ZERO,
        OP_COUNT_MUL,
        OP_COUNT_SCALE,
        OP_SET_COUNT,
        OP_DIV_STEP,
        OP_SET_STEP,
        OP_CLEAR_STEP
    } stg_op_t;

    typedef struct packed {
        stg_op_t op;
        logic    in_ready;
    } stg_ctrl_t;

    typedef struct packed {
        logic req_valid;
        logic req_start;
        logic tone_idle;
        logic rate_zero;
        logic out_free;
        logic div_busy;
    } stg_status_t;

endpackage

`default_nettype wire

// ----- sv/stg_quarter_rom.sv -----
// Quarter-wave sine table in Q1.15, built at elaboration, with registered read.
`default_nettype none

module stg_quarter_rom #(
    parameter int DEPTH = stg_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH + 1)
) (
    input  wire logic                      clk,
    input  wire logic [AW-1:0]             addr,
    output logic      [stg_pkg::MAG_W-1:0] rd_data
);

    localparam logic [63:0] PIO2_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_HALF = 64'd536870912;
    localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;
    localparam logic [8:1][8:0] TAYLOR_DIV = {
        9'd272, 9'd210, 9'd156, 9'd110, 9'd72, 9'd42, 9'd20, 9'd6
    };

    function automatic logic [DEPTH:0][stg_pkg::MAG_W-1:0] build_quarter();
        logic [DEPTH:0][stg_pkg::MAG_W-1:0] rom;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        rom = '0;
        for (int k = 0; k <= DEPTH; k++)
        begin
            x    = (PIO2_Q30 * 64'(k)) / 64'(DEPTH);
            term = x;
            sum  = signed'(x);
            for (int n = 1; n <= 8; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / 64'(TAYLOR_DIV[n]);
                if (n % 2 == 1)
                    sum = sum - signed'(term);
                else
                    sum = sum + signed'(term);
            end
            if (sum < 0)
                sum = '0;
            if (sum > Q30_ONE)
                sum = Q30_ONE;
            v = (unsigned'(sum) * 64'(stg_pkg::MAG_MAX) + Q30_HALF) >> 30;
            if (v > 64'(stg_pkg::MAG_MAX))
                v = 64'(stg_pkg::MAG_MAX);
            rom[k] = v[stg_pkg::MAG_W-1:0];
        end
        return rom;
    endfunction

    localparam logic [DEPTH:0][stg_pkg::MAG_W-1:0] QUARTER_ROM = build_quarter();

    logic [stg_pkg::MAG_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= QUARTER_ROM[addr];
    end

    assign rd_data = data_reg;

endmodule

`default_nettype wire

// ----- sv/stg_divider.sv -----
// Restoring serial divider, one quotient bit per clock.
`default_nettype none

module stg_divider #(
    parameter int DW = 48
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [15:0]   divisor,
    output logic               busy,
    output logic      [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [15:0]   rem_reg, rem_next;
    logic [15:0]   den_reg, den_next;
    logic [16:0]   trial;
    logic [16:0]   diff;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[DW-1]};
        diff      = trial - {1'b0, den_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[15:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- sv/stg_datapath.sv -----
// Datapath: tone registers, phase accumulator, table lookup, scaling and output slot.
`default_nettype none

module stg_datapath #(
    parameter int DEPTH      = stg_pkg::DEPTH_DEFAULT,
    parameter int PHASE_BITS = stg_pkg::PHASE_BITS_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire stg_pkg::stg_in_t    in_data,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output stg_pkg::stg_out_t        out_data,
    input  wire logic                cfg_write,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire stg_pkg::stg_ctrl_t  ctrl,
    output stg_pkg::stg_status_t     status
);

    localparam int QS     = PHASE_BITS - 2;
    localparam int AW     = $clog2(DEPTH + 1);
    localparam int DW     = PHASE_BITS + 16;
    localparam int PROD_W = QS + AW;
    localparam int MW     = stg_pkg::MAG_W;
    localparam int CNTW   = stg_pkg::COUNT_W;
    localparam int CPW    = 32 + $bits(stg_pkg::COUNT_RECIP);

    logic [15:0]           rate_reg;
    logic [MW-1:0]         amp_reg;
    logic [15:0]           freq_reg;
    logic [15:0]           dur_reg;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [PHASE_BITS-1:0] phase_step_reg, phase_step_next;
    logic [CNTW-1:0]       left_reg, left_next;
    logic [AW-1:0]         idx_reg;
    logic [1:0]            quad_reg;
    logic [2*MW-1:0]       prod_reg;
    logic [31:0]           count_prod_reg;
    logic [CNTW:0]         count_q_reg;
    logic                  out_valid_reg, out_valid_next;
    stg_pkg::stg_out_t     out_data_reg, out_data_next;

    logic [PROD_W-1:0]     idx_prod;
    logic [AW-1:0]         rom_addr;
    logic [MW-1:0]         rom_data;
    logic                  out_free;
    logic                  div_start;
    logic                  div_busy;
    logic [DW-1:0]         div_dividend;
    logic [15:0]           div_divisor;
    logic [DW-1:0]         div_quotient;
    logic [CPW-1:0]        count_scaled;
    logic [CNTW-1:0]       count_sat;
    logic [MW-1:0]         q0;
    logic [15:0]           rem_est;
    logic [15:0]           scaled;
    logic [15:0]           sample_mag;

    // Table index: floor(rest * DEPTH / 2^QS), mirrored in the odd quadrants
    assign idx_prod = PROD_W'(phase_reg[QS-1:0]) * PROD_W'(DEPTH);
    assign rom_addr = quad_reg[0] ? (AW'(DEPTH) - idx_reg) : idx_reg;

    stg_quarter_rom #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_rom (
        .clk     (clk),
        .addr    (rom_addr),
        .rd_data (rom_data)
    );

    // Divide rate*duration by 1000 through a reciprocal multiply
    assign count_scaled = CPW'(count_prod_reg) * CPW'(stg_pkg::COUNT_RECIP);
    assign count_sat    = count_q_reg[CNTW] ? stg_pkg::COUNT_MAX : count_q_reg[CNTW-1:0];

    assign div_start    = (ctrl.op == stg_pkg::OP_DIV_STEP);
    assign div_dividend = {freq_reg, {PHASE_BITS{1'b0}}};
    assign div_divisor  = rate_reg;

    stg_divider #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Divide by 32767: p = q0*32767 + (q0 + low bits), then fix up by at most two
    assign q0      = prod_reg[2*MW-1:MW];
    assign rem_est = {1'b0, prod_reg[MW-1:0]} + {1'b0, q0};
    always_comb
    begin
        if (rem_est >= {stg_pkg::MAG_MAX, 1'b0})
            scaled = {1'b0, q0} + 16'd2;
        else if (rem_est >= {1'b0, stg_pkg::MAG_MAX})
            scaled = {1'b0, q0} + 16'd1;
        else
            scaled = {1'b0, q0};
    end
    assign sample_mag = scaled;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        phase_next      = phase_reg;
        phase_step_next = phase_step_reg;
        left_next       = left_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (ctrl.op)
            stg_pkg::OP_SET_COUNT:
            begin
                left_next  = count_sat;
                phase_next = '0;
            end
            stg_pkg::OP_SET_STEP:
            begin
                phase_step_next = div_quotient[PHASE_BITS-1:0];
            end
            stg_pkg::OP_CLEAR_STEP:
            begin
                phase_step_next = '0;
            end
            stg_pkg::OP_EMIT_TONE:
            begin
                out_valid_next       = 1'b1;
                out_data_next.sample = quad_reg[1] ? -sample_mag : sample_mag;
                out_data_next.last   = (left_reg == CNTW'(1));
                out_data_next.active = 1'b1;
                left_next            = left_reg - CNTW'(1);
                phase_next           = phase_reg + phase_step_reg;
            end
            stg_pkg::OP_EMIT_ZERO:
            begin
                out_valid_next       = 1'b1;
                out_data_next.sample = '0;
                out_data_next.last   = 1'b0;
                out_data_next.active = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg       <= stg_pkg::RATE_RESET;
            amp_reg        <= stg_pkg::AMP_RESET;
            phase_reg      <= '0;
            phase_step_reg <= '0;
            left_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    stg_pkg::REG_SAMPLE_RATE: rate_reg <= cfg_data;
                    stg_pkg::REG_AMPLITUDE:   amp_reg  <= cfg_data[MW-1:0];
                    default:
                    begin
                    end
                endcase
            end
            phase_reg      <= phase_next;
            phase_step_reg <= phase_step_next;
            left_reg       <= left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (ctrl.op == stg_pkg::OP_ACCEPT)
        begin
            freq_reg <= in_data.tone_frequency;
            dur_reg  <= in_data.duration_ms;
        end
        if (ctrl.op == stg_pkg::OP_COUNT_MUL)
            count_prod_reg <= 32'(rate_reg) * 32'(dur_reg);
        if (ctrl.op == stg_pkg::OP_COUNT_SCALE)
            count_q_reg <= count_scaled[stg_pkg::COUNT_RECIP_SHIFT +: CNTW+1];
        if (ctrl.op == stg_pkg::OP_INDEX)
        begin
            idx_reg  <= idx_prod[QS +: AW];
            quad_reg <= phase_reg[PHASE_BITS-1 -: 2];
        end
        if (ctrl.op == stg_pkg::OP_MUL)
            prod_reg <= (2*MW)'(amp_reg) * (2*MW)'(rom_data);
    end

    assign status.req_valid = in_valid;
    assign status.req_start = in_data.mode;
    assign status.tone_idle = (left_reg == '0);
    assign status.rate_zero = (rate_reg == '0);
    assign status.out_free  = out_free;
    assign status.div_busy  = div_busy;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- sv/stg_sequencer.sv -----
// Microcode sequencer: step counter, control store and branch logic.
`default_nettype none

module stg_sequencer (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire stg_pkg::stg_status_t status,
    output stg_pkg::stg_ctrl_t        ctrl
);

    typedef enum logic [1:0] {
        HOLD_NONE,
        HOLD_IN,
        HOLD_OUT,
        HOLD_DIV
    } hold_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_START,
        COND_IDLE,
        COND_RATE_ZERO
    } cond_t;

    typedef struct packed {
        stg_pkg::stg_op_t op;
        hold_t            hold;
        cond_t            cond;
        logic [3:0]       target;
    } uword_t;

    localparam logic [3:0] S_WAIT     = 4'd0;
    localparam logic [3:0] S_TICK     = 4'd1;
    localparam logic [3:0] S_READ     = 4'd2;
    localparam logic [3:0] S_MUL      = 4'd3;
    localparam logic [3:0] S_EMIT     = 4'd4;
    localparam logic [3:0] S_ZERO     = 4'd5;
    localparam logic [3:0] S_START    = 4'd6;
    localparam logic [3:0] S_CSCALE   = 4'd7;
    localparam logic [3:0] S_SETCNT   = 4'd8;
    localparam logic [3:0] S_STEPDIV  = 4'd9;
    localparam logic [3:0] S_WSTEP    = 4'd10;
    localparam logic [3:0] S_SETSTEP  = 4'd11;
    localparam logic [3:0] S_ZSTEP    = 4'd12;

    function automatic uword_t micro_word(input logic [3:0] step);
        uword_t w;
        case (step)
            S_WAIT:    w = '{stg_pkg::OP_ACCEPT,      HOLD_IN,   COND_START,     S_START};
            S_TICK:    w = '{stg_pkg::OP_INDEX,       HOLD_NONE, COND_IDLE,      S_ZERO};
            S_READ:    w = '{stg_pkg::OP_NONE,        HOLD_NONE, COND_NEXT,      S_WAIT};
            S_MUL:     w = '{stg_pkg::OP_MUL,         HOLD_NONE, COND_NEXT,      S_WAIT};
            S_EMIT:    w = '{stg_pkg::OP_EMIT_TONE,   HOLD_OUT,  COND_ALWAYS,    S_WAIT};
            S_ZERO:    w = '{stg_pkg::OP_EMIT_ZERO,   HOLD_OUT,  COND_ALWAYS,    S_WAIT};
            S_START:   w = '{stg_pkg::OP_COUNT_MUL,   HOLD_NONE, COND_NEXT,      S_WAIT};
            S_CSCALE:  w = '{stg_pkg::OP_COUNT_SCALE, HOLD_NONE, COND_NEXT,      S_WAIT};
            S_SETCNT:  w = '{stg_pkg::OP_SET_COUNT,   HOLD_NONE, COND_RATE_ZERO, S_ZSTEP};
            S_STEPDIV: w = '{stg_pkg::OP_DIV_STEP,    HOLD_NONE, COND_NEXT,      S_WAIT};
            S_WSTEP:   w = '{stg_pkg::OP_NONE,        HOLD_DIV,  COND_NEXT,      S_WAIT};
            S_SETSTEP: w = '{stg_pkg::OP_SET_STEP,    HOLD_NONE, COND_ALWAYS,    S_ZERO};
            S_ZSTEP:   w = '{stg_pkg::OP_CLEAR_STEP,  HOLD_NONE, COND_ALWAYS,    S_ZERO};
            default:   w = '{stg_pkg::OP_NONE,        HOLD_NONE, COND_ALWAYS,    S_WAIT};
        endcase
        return w;
    endfunction

    logic [3:0] step_reg, step_next;
    uword_t     uw;
    logic       held;
    logic       taken;

    assign uw = micro_word(step_reg);

    always_comb
    begin
        case (uw.hold)
            HOLD_IN:  held = !status.req_valid;
            HOLD_OUT: held = !status.out_free;
            HOLD_DIV: held = status.div_busy;
            default:  held = 1'b0;
        endcase
        case (uw.cond)
            COND_ALWAYS:    taken = 1'b1;
            COND_START:     taken = status.req_start;
            COND_IDLE:      taken = status.tone_idle;
            COND_RATE_ZERO: taken = status.rate_zero;
            default:        taken = 1'b0;
        endcase
        if (held)
            step_next = step_reg;
        else if (taken)
            step_next = uw.target;
        else
            step_next = step_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= S_WAIT;
        else
            step_reg <= step_next;
    end

    // Suppress the step's operation while it waits
    assign ctrl.op       = held ? stg_pkg::OP_NONE : uw.op;
    assign ctrl.in_ready = (uw.hold == HOLD_IN);

endmodule

`default_nettype wire

// ----- sv/sine_tone_generator.sv -----
// Top level of the sine tone generator: sequencer plus datapath.
`default_nettype none

// Direct digital synthesis tone source driven by a small microcode program.
// A start request loads a tone: sample count = rate*duration/1000 (saturated
// to 22 bits, taken by a registered multiply and a reciprocal multiply) and
// phase step = frequency*2^PHASE_BITS/rate from a serial divider that yields
// one quotient bit per clock, then answers with a zero sample. Each tick
// request returns amplitude*sin(phase) from a quarter-wave table read through
// one registered ROM port, or a zero sample once no tone is left. A tick
// registers its table index and quadrant, reads the ROM, registers the scaled
// product and writes the output register, waiting while it is still full. A
// start result waits for the divider pass; with a zero sample rate the divide
// is skipped. The block handles one request at a time; a finished result
// waits in the output register while the next request is taken. The table
// is built at elaboration and needs no load after reset.
module sine_tone_generator #(
    parameter int QUARTER_TABLE_DEPTH = stg_pkg::DEPTH_DEFAULT,
    parameter int PHASE_BITS          = stg_pkg::PHASE_BITS_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire stg_pkg::stg_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output stg_pkg::stg_out_t      out_data,
    input  wire logic              cfg_write,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);

    stg_pkg::stg_ctrl_t   ctrl;
    stg_pkg::stg_status_t status;

    stg_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    stg_datapath #(
        .DEPTH      (QUARTER_TABLE_DEPTH),
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .status    (status)
    );

    assign in_ready = ctrl.in_ready;

endmodule

`default_nettype wire

// ----- bench/tb_sine_tone_generator.sv -----
// Self-checking testbench for the sine tone generator top level.
module tb_sine_tone_generator;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64_t;

    localparam int DEPTH           = stg_pkg::DEPTH_DEFAULT;
    localparam int PH              = stg_pkg::PHASE_BITS_DEFAULT;
    localparam int MW              = stg_pkg::MAG_W;
    localparam int CW              = stg_pkg::COUNT_W;
    localparam int SETTLE_CYCLES   = 20;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 71;
    localparam int PRINT_LIMIT     = 100;

    localparam logic       MODE_TICK    = 1'b0;
    localparam logic       MODE_START   = 1'b1;
    localparam logic [1:0] REG_RATE     = stg_pkg::REG_SAMPLE_RATE;
    localparam logic [1:0] REG_AMP      = stg_pkg::REG_AMPLITUDE;
    localparam logic [1:0] REG_SPARE_LO = 2'd2;
    localparam logic [1:0] REG_SPARE_HI = 2'd3;
    localparam bit         TYPED        = 1'b1;
    localparam bit         PREDICTED    = 1'b0;

    typedef enum bit {ROW_REQ, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [1:0]        reg_index;
        logic [15:0]       reg_value;
        stg_pkg::stg_in_t  req;
        bit                typed;
        stg_pkg::stg_out_t want;
    } plan_row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    stg_pkg::stg_in_t  in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    stg_pkg::stg_out_t out_data;
    logic              cfg_write = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [15:0]       cfg_data  = '0;

    sine_tone_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Tone state mirrored from the block.
    int            sine_q15 [0:DEPTH];
    logic [15:0]   rate_hz    = stg_pkg::RATE_RESET;
    logic [MW-1:0] amp_q      = stg_pkg::AMP_RESET;
    logic [PH-1:0] tone_phase = '0;
    logic [PH-1:0] tone_step  = '0;
    logic [CW-1:0] tone_left  = '0;

    stg_pkg::stg_out_t expected_samples [$];
    plan_row_t         plan [$];

    int send_idle_pct = 23;
    int recv_idle_pct = 51;
    int err_count     = 0;
    int items_sent    = 0;
    int starts_sent   = 0;
    int regs_written  = 0;
    int results_seen  = 0;
    int ends_seen     = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Quarter-wave table: Taylor series in Q2.30, then scaled to Q1.15.
    initial
    begin : build_sine
        u64_t    x;
        u64_t    term;
        longint  sum;
        u64_t    v;
        for (int k = 0; k <= DEPTH; k++)
        begin
            x    = (64'd1686629713 * k) / DEPTH;
            term = x;
            sum  = longint'(x);
            for (int n = 1; n <= 8; n++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = term / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            if (sum < 0)
                sum = 0;
            if (sum > 64'sd1073741824)
                sum = 64'sd1073741824;
            v = (u64_t'(sum) * 32767 + (64'd1 << 29)) >> 30;
            if (v > 32767)
                v = 32767;
            sine_q15[k] = int'(v);
        end
    end

    function automatic stg_pkg::stg_out_t tone_next(input stg_pkg::stg_in_t req);
        stg_pkg::stg_out_t res;
        u64_t              count;
        u64_t              idx;
        logic [PH-3:0]     rest;
        int                s;
        int                scaled;
        res = '0;
        if (req.mode == MODE_START)
        begin
            count      = (u64_t'(rate_hz) * u64_t'(req.duration_ms)) / stg_pkg::COUNT_DIVISOR;
            tone_left  = (count > stg_pkg::COUNT_MAX) ? stg_pkg::COUNT_MAX : count[CW-1:0];
            tone_step  = (rate_hz == '0) ? '0
                       : PH'((u64_t'(req.tone_frequency) << PH) / rate_hz);
            tone_phase = '0;
        end
        else if (tone_left != '0)
        begin
            rest = tone_phase[PH-3:0];
            idx  = (u64_t'(rest) * DEPTH) >> (PH - 2);
            // Mirror the quarter wave by quadrant.
            case (tone_phase[PH-1:PH-2])
                2'd0:    s = sine_q15[idx];
                2'd1:    s = sine_q15[DEPTH - idx];
                2'd2:    s = -sine_q15[idx];
                default: s = -sine_q15[DEPTH - idx];
            endcase
            scaled     = (int'(amp_q) * ((s < 0) ? -s : s)) / int'(stg_pkg::MAG_MAX);
            res.sample = 16'((s < 0) ? -scaled : scaled);
            res.last   = (tone_left == 1);
            res.active = 1'b1;
            tone_left  = tone_left - 1'b1;
            tone_phase = tone_phase + tone_step;
        end
        return res;
    endfunction

    function automatic plan_row_t req_row(input logic mode, input int freq, input int dur,
                                          input bit typed, input int smp, input bit last,
                                          input bit act);
        plan_row_t row;
        row.kind               = ROW_REQ;
        row.reg_index          = '0;
        row.reg_value          = '0;
        row.req.mode           = mode;
        row.req.tone_frequency = 16'(freq);
        row.req.duration_ms    = 16'(dur);
        row.typed              = typed;
        row.want.sample        = 16'(smp);
        row.want.last          = last;
        row.want.active        = act;
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [1:0] index, input int value);
        plan_row_t row;
        row           = req_row(MODE_TICK, 0, 0, PREDICTED, 0, 1'b0, 1'b0);
        row.kind      = ROW_REG;
        row.reg_index = index;
        row.reg_value = 16'(value);
        return row;
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    // Present one request, hold it until taken, then record its expected result.
    task automatic send_request(input stg_pkg::stg_in_t req, input bit typed,
                                input stg_pkg::stg_out_t typed_want);
        stg_pkg::stg_out_t want;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = tone_next(req);
        expected_samples.push_back(typed ? typed_want : want);
        items_sent++;
        if (req.mode == MODE_START)
            starts_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every request has answered.
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (index)
            REG_RATE: rate_hz = value;
            REG_AMP:  amp_q   = value[MW-1:0];
            default: ;
        endcase
        regs_written++;
        @(negedge clk);
    endtask

    task automatic check_sample(input stg_pkg::stg_out_t got);
        stg_pkg::stg_out_t want;
        results_seen++;
        if (got.last)
            ends_seen++;
        if (expected_samples.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending: sample %0d last %0b active %0b",
                                      got.sample, got.last, got.active));
            return;
        end
        want = expected_samples.pop_front();
        if (got.sample !== want.sample)
            report_mismatch($sformatf("result %0d sample %0d, want %0d",
                                      results_seen, got.sample, want.sample));
        if (got.last !== want.last)
            report_mismatch($sformatf("result %0d last %0b, want %0b",
                                      results_seen, got.last, want.last));
        if (got.active !== want.active)
            report_mismatch($sformatf("result %0d active %0b, want %0b",
                                      results_seen, got.active, want.active));
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_sample(out_data);
    end

    initial
    begin : stimulus
        stg_pkg::stg_in_t req;
        int unsigned      count;
        int unsigned      dur_max;
        int unsigned      n_ticks;
        int               target;

        //                    mode        freq    dur     check      smp     last  act
        plan.push_back(req_row(MODE_TICK,  0,      0,      TYPED,     0,      1'b0, 1'b0));
        plan.push_back(req_row(MODE_START, 1000,   1,      TYPED,     0,      1'b0, 1'b0));
        plan.push_back(req_row(MODE_TICK,  0,      0,      TYPED,     0,      1'b0, 1'b1));
        plan.push_back(req_row(MODE_TICK,  65535,  65535,  PREDICTED, 0,      1'b0, 1'b0));
        plan.push_back(req_row(MODE_TICK,  0,      0,      PREDICTED, 0,      1'b0, 1'b0));
        // zero duration leaves the block idle
        plan.push_back(req_row(MODE_START, 4000,   0,      TYPED,     0,      1'b0, 1'b0));
        plan.push_back(req_row(MODE_TICK,  0,      0,      TYPED,     0,      1'b0, 1'b0));
        plan.push_back(reg_row(REG_RATE, 0));
        plan.push_back(req_row(MODE_START, 1000,   100,    TYPED,     0,      1'b0, 1'b0));
        plan.push_back(req_row(MODE_TICK,  0,      0,      TYPED,     0,      1'b0, 1'b0));
        // quarter-turn step: zero, positive peak, zero, negative peak, then done
        plan.push_back(reg_row(REG_RATE, 4000));
        plan.push_back(reg_row(REG_AMP, 32767));
        plan.push_back(req_row(MODE_START, 1000,   1,      TYPED,     0,      1'b0, 1'b0));
        plan.push_back(req_row(MODE_TICK,  0,      0,      TYPED,     0,      1'b0, 1'b1));
        plan.push_back(req_row(MODE_TICK,  0,      0,      TYPED,     32767,  1'b0, 1'b1));
        plan.push_back(req_row(MODE_TICK,  0,      0,      TYPED,     0,      1'b0, 1'b1));
        plan.push_back(req_row(MODE_TICK,  0,      0,      TYPED,     -32767, 1'b1, 1'b1));
        plan.push_back(req_row(MODE_TICK,  0,      0,      TYPED,     0,      1'b0, 1'b0));
        // saturated count and a step that wraps to zero; spare indexes are ignored
        plan.push_back(reg_row(REG_RATE, 65535));
        plan.push_back(reg_row(REG_SPARE_LO, 0));
        plan.push_back(reg_row(REG_SPARE_HI, 65535));
        plan.push_back(req_row(MODE_START, 65535,  65535,  TYPED,     0,      1'b0, 1'b0));
        plan.push_back(req_row(MODE_TICK,  0,      0,      TYPED,     0,      1'b0, 1'b1));
        plan.push_back(req_row(MODE_TICK,  0,      0,      TYPED,     0,      1'b0, 1'b1));
        // restart in the middle of a tone
        plan.push_back(req_row(MODE_START, 12345,  7,      TYPED,     0,      1'b0, 1'b0));
        plan.push_back(req_row(MODE_TICK,  0,      0,      PREDICTED, 0,      1'b0, 1'b0));
        plan.push_back(req_row(MODE_TICK,  0,      0,      PREDICTED, 0,      1'b0, 1'b0));
        plan.push_back(reg_row(REG_AMP, 0));
        plan.push_back(req_row(MODE_START, 23130,  42405,  TYPED,     0,      1'b0, 1'b0));
        plan.push_back(req_row(MODE_TICK,  0,      0,      TYPED,     0,      1'b0, 1'b1));
        plan.push_back(req_row(MODE_TICK,  0,      0,      TYPED,     0,      1'b0, 1'b1));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_REG)
            begin
                settle_idle();
                write_reg(plan[r].reg_index, plan[r].reg_value);
            end
            else
                send_request(plan[r].req, plan[r].typed, plan[r].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p / 2)
                0:
                begin
                    send_idle_pct = 23;
                    recv_idle_pct = 51;
                end
                1:
                begin
                    send_idle_pct = 51;
                    recv_idle_pct = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            settle_idle();
            case (p)
                0:       write_reg(REG_RATE, 16'd8000);
                1:       write_reg(REG_RATE, 16'd48000);
                2:       write_reg(REG_RATE, 16'($urandom_range(0, 65535)));
                default: write_reg(REG_RATE, 16'($urandom_range(8000, 48000)));
            endcase
            case (p)
                0:       write_reg(REG_AMP, 16'(stg_pkg::MAG_MAX));
                3:       write_reg(REG_AMP, 16'd0);
                default: write_reg(REG_AMP, 16'($urandom_range(0, 65535)));
            endcase
            if ($urandom_range(0, 1))
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom()));

            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                req.tone_frequency = 16'($urandom());
                req.duration_ms    = 16'($urandom());
                case ($urandom_range(0, 9))
                    0:
                    begin
                        req.mode = 1'($urandom());
                        send_request(req, PREDICTED, '0);
                    end
                    1:
                    begin
                        // long tone, abandoned by whatever start comes next
                        req.mode = MODE_START;
                        send_request(req, PREDICTED, '0);
                        req.mode = MODE_TICK;
                        repeat ($urandom_range(1, 8)) send_request(req, PREDICTED, '0);
                    end
                    default:
                    begin
                        // short tone played out, sometimes cut, sometimes overrun
                        dur_max = (rate_hz == 0) ? 65535 : 30000 / rate_hz;
                        if (dur_max == 0)
                            dur_max = 1;
                        if (dur_max > 65535)
                            dur_max = 65535;
                        req.mode = MODE_START;
                        if ($urandom_range(0, 1))
                            req.tone_frequency = 16'($urandom_range(0, rate_hz / 2));
                        req.duration_ms = 16'($urandom_range(0, dur_max));
                        count = (rate_hz * req.duration_ms) / 1000;
                        send_request(req, PREDICTED, '0);
                        n_ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, count)
                                : count + $urandom_range(0, 2);
                        repeat (n_ticks)
                        begin
                            req.mode           = MODE_TICK;
                            req.tone_frequency = 16'($urandom());
                            req.duration_ms    = 16'($urandom());
                            send_request(req, PREDICTED, '0);
                        end
                    end
                endcase
            end
        end

        settle_idle();
        $display("covered %0d requests (%0d tone starts) over %0d register writes",
                 items_sent, starts_sent, regs_written);
        $display("checked %0d results, %0d tone ends, %0d mismatches",
                 results_seen, ends_seen, err_count);
        if (err_count == 0 && expected_samples.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("run stopped at %0t with %0d results outstanding",
                 $time, expected_samples.size());
        $display("status: fail");
        $finish;
    end

endmodule
